[sv/lba_to_chs_converter_defines.svh]
// Assertion macros shared by the LBA to CHS converter RTL.
`ifndef LBA_TO_CHS_CONVERTER_DEFINES_SVH
`define LBA_TO_CHS_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LBAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lba_to_chs_converter assertion failed");

// Next-cycle implication, checked outside reset.
`define LBAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lba_to_chs_converter assertion failed");

`endif

[sv/lbac_pkg.sv]
// Package with types and constants of the LBA to CHS converter.
`timescale 1ns / 1ps
`default_nettype none

package lbac_pkg;

  // Address bits that take part in the conversion.
  localparam int unsigned LbaWidth = 64;
  localparam logic [63:0] LbaMask = {64{1'b1}} >> (64 - LbaWidth);

  // Division steps: ten for the cylinder, eight for the head.
  localparam int unsigned CylSteps  = 10;
  localparam int unsigned HeadSteps = 8;
  localparam int unsigned NumCells  = CylSteps + HeadSteps;

  localparam logic [7:0] HpcReset = 8'd255;
  localparam logic [5:0] SptReset = 6'd63;

  // Packed word of the protective tuple (1023,255,63).
  localparam logic [23:0] ProtectiveChs = 24'hFFFFFF;

  typedef enum logic [1:0] {
    CfgHeads   = 2'd0,
    CfgSectors = 2'd1
  } lbac_cfg_e;

  // One item as it travels down the row of cells.
  typedef struct packed {
    logic        valid;
    logic        prot;
    logic [23:0] rem;
    logic [23:0] dvs;
    logic [9:0]  quo;
    logic [9:0]  cyl;
    logic [5:0]  spt;
  } lbac_lane_t;

endpackage

`default_nettype wire

[sv/lbac_front.sv]
// Input stage: geometry product, range check and saturation of the address.
`timescale 1ns / 1ps
`default_nettype none

module lbac_front import lbac_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        in_valid_i,
  input  wire logic [63:0] block_address_i,
  input  wire logic        protective_clamp_i,
  input  wire logic [7:0]  hpc_i,
  input  wire logic [5:0]  spt_i,
  output lbac_lane_t       lane_o
);

  logic [7:0]  hpc_eff;
  logic [5:0]  spt_eff;
  logic [13:0] prod;
  logic [23:0] top;
  logic [63:0] lba_m;
  logic        over;
  lbac_lane_t  lane_d, lane_q;

  // A zero geometry register counts as one.
  assign hpc_eff = (hpc_i == 8'd0) ? 8'd1 : hpc_i;
  assign spt_eff = (spt_i == 6'd0) ? 6'd1 : spt_i;
  assign prod    = {6'b0, hpc_eff} * {8'b0, spt_eff};
  assign top     = {prod, 10'b0} - 24'd1;
  assign lba_m   = block_address_i & LbaMask;
  assign over    = (|lba_m[63:24]) || (lba_m[23:0] > top);

  always_comb begin
    lane_d.valid = in_valid_i;
    lane_d.prot  = over & protective_clamp_i;
    lane_d.rem   = over ? top : lba_m[23:0];
    lane_d.dvs   = {1'b0, prod, 9'b0};
    lane_d.quo   = '0;
    lane_d.cyl   = '0;
    lane_d.spt   = spt_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

`default_nettype wire

[sv/lbac_cell.sv]
// One restoring division step with its pipeline register.
`timescale 1ns / 1ps
`default_nettype none

module lbac_cell import lbac_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire lbac_lane_t lane_i,
  output lbac_lane_t      lane_o
);

  logic       ge;
  lbac_lane_t lane_d, lane_q;

  assign ge = lane_i.rem >= lane_i.dvs;

  always_comb begin
    lane_d     = lane_i;
    lane_d.rem = ge ? (lane_i.rem - lane_i.dvs) : lane_i.rem;
    lane_d.quo = {lane_i.quo[8:0], ge};
    lane_d.dvs = {1'b0, lane_i.dvs[23:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

`default_nettype wire

[sv/lba_to_chs_converter.sv]
// Converts a logical block address into a packed partition-table CHS word.
//
// Input channel: block_address_i and protective_clamp_i, transferred when
// in_valid_i is high and in_stall_o is low. Output channel: packed_chs_o,
// transferred when out_valid_o is high and out_stall_i is low.
// Geometry is set through the write port: index 0 is heads per cylinder,
// index 1 is sectors per track; other indexes are ignored.
// An input transfer reaches the output through the input stage, eighteen
// division cells (ten for the cylinder, eight for the head) and the output
// register.
// Throughput is one item per cycle while the receiver takes results; the whole row advances together.
// When the receiver stalls with a result waiting, the row holds and
// in_stall_o rises until the result is taken.
// Reset empties the row and loads the geometry 255 heads, 63 sectors.
`timescale 1ns / 1ps
`default_nettype none

`include "lba_to_chs_converter_defines.svh"

module lba_to_chs_converter import lbac_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] block_address_i,
  input  wire logic        protective_clamp_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [23:0]      packed_chs_o
);

  logic [7:0]  hpc_q;
  logic [5:0]  spt_q;
  logic        en;
  logic        out_valid_q;
  logic [23:0] packed_q, packed_d;
  logic [5:0]  sector;
  lbac_lane_t  lane_in  [NumCells];
  lbac_lane_t  lane_out [NumCells+1];
  lbac_lane_t  last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpc_q <= HpcReset;
      spt_q <= SptReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgHeads:   hpc_q <= cfg_wdata_i;
        CfgSectors: spt_q <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  lbac_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en_i               (en),
    .in_valid_i         (in_valid_i),
    .block_address_i    (block_address_i),
    .protective_clamp_i (protective_clamp_i),
    .hpc_i              (hpc_q),
    .spt_i              (spt_q),
    .lane_o             (lane_out[0])
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    if (k == CylSteps) begin : g_turn
      // The cylinder quotient is done; the remainder is now divided by spt.
      always_comb begin
        lane_in[k]     = lane_out[k];
        lane_in[k].cyl = lane_out[k].quo;
        lane_in[k].quo = '0;
        lane_in[k].dvs = {11'b0, lane_out[k].spt, 7'b0};
      end
    end else begin : g_pass
      assign lane_in[k] = lane_out[k];
    end

    lbac_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .lane_i (lane_in[k]),
      .lane_o (lane_out[k+1])
    );
  end

  assign last   = lane_out[NumCells];
  assign sector = last.rem[5:0] + 6'd1;

  always_comb begin
    if (last.prot) begin
      packed_d = ProtectiveChs;
    end else begin
      packed_d = {last.cyl[7:0], last.cyl[9:8], sector, last.quo[7:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      packed_q <= packed_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign packed_chs_o = packed_q;

  `LBAC_ASSERT_NEXT(a_prot_tuple, clk_i, rst_ni, en && last.valid && last.prot,
    packed_chs_o == ProtectiveChs)
  `LBAC_ASSERT_NOW(a_sector_nonzero, clk_i, rst_ni, out_valid_o,
    packed_chs_o[13:8] != 6'd0)
  `LBAC_ASSERT_NOW(a_rem_below_spt, clk_i, rst_ni, last.valid && !last.prot,
    last.rem < {18'b0, last.spt})

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the LBA to CHS converter.
`timescale 1ns / 1ps

module testbench;
  import lbac_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned TailCycles  = 40;
  localparam int unsigned PhaseItems  = 100;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PrintLimit  = 30;

  // Indexes past the register list; writes to them must leave the geometry alone.
  localparam logic [1:0] CfgSpareLow  = 2'd2;
  localparam logic [1:0] CfgSpareHigh = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = CfgHeads;
  logic [7:0]  cfg_wdata_i = 8'h00;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] block_address_i = 64'h0;
  logic        protective_clamp_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [23:0] packed_chs_o;

  // Geometry as the block should hold it.
  logic [7:0] geo_heads = HpcReset;
  logic [5:0] geo_sectors = SptReset;

  logic [23:0] chs_expected_q[$];

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned clamped_items = 0;
  int unsigned geometry_writes = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          source_steady = 1'b0;
  bit          sink_steady = 1'b0;

  lba_to_chs_converter u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .block_address_i    (block_address_i),
    .protective_clamp_i (protective_clamp_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .packed_chs_o       (packed_chs_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, chs_expected_q.size());
      $display("lba_to_chs_converter verification failed");
      $finish;
    end
  end

  // A zero register counts as one so the divisions stay defined.
  function automatic logic [63:0] active_heads();
    return (geo_heads == 8'd0) ? 64'd1 : 64'(geo_heads);
  endfunction

  function automatic logic [63:0] active_sectors();
    return (geo_sectors == 6'd0) ? 64'd1 : 64'(geo_sectors);
  endfunction

  function automatic logic [63:0] geometry_top();
    return 64'd1024 * active_heads() * active_sectors() - 64'd1;
  endfunction

  function automatic logic [23:0] predict_chs(logic [63:0] address, logic protect);
    logic [63:0] lba;
    logic [63:0] top;
    logic [63:0] cyl;
    logic [63:0] head;
    logic [63:0] sector;
    lba = address & LbaMask;
    top = geometry_top();
    if (lba > top) begin
      if (protect) return ProtectiveChs;
      lba = top;
    end
    cyl    = lba / (active_heads() * active_sectors());
    head   = (lba / active_sectors()) % active_heads();
    sector = (lba % active_sectors()) + 64'd1;
    return {cyl[7:0], cyl[9:8], sector[5:0], head[7:0]};
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    mismatches++;
    if (mismatches <= PrintLimit)
      $display("[%0t] %s: got %06h (c%0d h%0d s%0d), expected %06h (c%0d h%0d s%0d)",
               $realtime, what, got, {got[15:14], got[23:16]}, got[7:0], got[13:8],
               want, {want[15:14], want[23:16]}, want[7:0], want[13:8]);
  endtask

  always @(posedge clk_i) begin : check_results
    logic [23:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (chs_expected_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", packed_chs_o, 24'h0);
      end else begin
        want = chs_expected_q.pop_front();
        if (packed_chs_o !== want) report_mismatch("packed_chs", packed_chs_o, want);
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left == 0 && !sink_steady && $urandom_range(0, 99) < 20)
      stall_left = gap_length();
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Returns right after the rising edge at which the transfer happened.
  task automatic send_address(logic [63:0] address, logic protect);
    int unsigned gap;
    @(negedge clk_i);
    gap = (!source_steady && $urandom_range(0, 99) < 35) ? gap_length() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    block_address_i    <= address;
    protective_clamp_i <= protect;
    do @(posedge clk_i); while (in_stall_o);
    chs_expected_q.push_back(predict_chs(address, protect));
    if ((address & LbaMask) > geometry_top()) clamped_items++;
    items_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (chs_expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Only called with the pipeline empty.
  task automatic write_geometry(logic [1:0] index, logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (index)
      CfgHeads:   geo_heads = value;
      CfgSectors: geo_sectors = value[5:0];
      default:    ;
    endcase
    geometry_writes++;
  endtask

  task automatic test_default_geometry();
    send_address(64'd0, 1'b0);
    send_address(64'd0, 1'b1);
    send_address(64'd62, 1'b0);
    send_address(64'd63, 1'b0);
    send_address(64'd16065, 1'b0);
    send_address(64'd16450559, 1'b0);
    send_address(64'd16450559, 1'b1);
    send_address(64'd16450560, 1'b0);
    send_address(64'd16450560, 1'b1);
    send_address({64{1'b1}}, 1'b0);
    send_address({64{1'b1}}, 1'b1);
    send_address(64'h8000_0000_0000_0000, 1'b0);
    send_address(64'h0000_0001_0000_0000, 1'b1);
    wait_for_results();
  endtask

  task automatic test_register_corners();
    // Zero in both registers behaves as one head and one sector.
    write_geometry(CfgHeads, 8'd0);
    write_geometry(CfgSectors, 8'd0);
    send_address(64'd1023, 1'b0);
    send_address(64'd1024, 1'b0);
    send_address(64'd1024, 1'b1);
    wait_for_results();
    // The upper two data bits do not reach the sector register.
    write_geometry(CfgSectors, 8'hFF);
    write_geometry(CfgHeads, 8'd1);
    send_address(64'd64511, 1'b0);
    send_address(64'd64512, 1'b1);
    wait_for_results();
    write_geometry(CfgSpareLow, 8'h05);
    write_geometry(CfgSpareHigh, 8'h00);
    send_address(64'd100, 1'b0);
    wait_for_results();
    write_geometry(CfgHeads, 8'd255);
    write_geometry(CfgSectors, 8'd1);
    send_address(64'd261119, 1'b0);
    send_address(64'd261120, 1'b0);
    send_address(64'd261120, 1'b1);
    wait_for_results();
  endtask

  function automatic logic [63:0] pick_address();
    logic [63:0] top;
    logic [63:0] span;
    top  = geometry_top();
    span = active_heads() * active_sectors();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 64'($urandom_range(0, top[31:0]));
      4:          return top - 64'd4 + 64'($urandom_range(0, 8));
      5:          return span * 64'($urandom_range(0, 1023)) + 64'($urandom_range(0, 2))
                         - 64'd1;
      6:          return {$urandom, $urandom};
      7:          return top + 64'd1 + 64'($urandom_range(0, 1 << 20));
      8:          return 64'($urandom_range(0, 200));
      default:    return span * 64'd1023 + 64'($urandom_range(0, span[31:0] - 1));
    endcase
  endfunction

  function automatic logic [7:0] pick_register(logic [7:0] upper);
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return upper;
      default: return 8'($urandom_range(1, upper));
    endcase
  endfunction

  task automatic test_random_geometry();
    int unsigned phase;
    int unsigned k;
    logic [7:0]  sectors;
    for (phase = 0; phase < NumPhases; phase++) begin
      write_geometry(CfgHeads, pick_register(8'd255));
      // Random upper bits on the sector write must be dropped.
      sectors = pick_register(8'd63);
      write_geometry(CfgSectors, {2'($urandom_range(0, 3)), sectors[5:0]});
      if ($urandom_range(0, 2) == 0)
        write_geometry($urandom_range(0, 1) ? CfgSpareLow : CfgSpareHigh, 8'($urandom));
      source_steady = ($urandom_range(0, 3) == 0);
      sink_steady   = ($urandom_range(0, 3) == 0);
      for (k = 0; k < PhaseItems; k++) begin
        send_address(pick_address(), 1'($urandom_range(0, 1)));
        // Let the pipeline run dry once in the middle of a phase.
        if (phase == 3 && k == PhaseItems / 2) wait_for_results();
      end
      wait_for_results();
    end
    source_steady = 1'b0;
    sink_steady   = 1'b0;
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_default_geometry();
    test_register_corners();
    test_random_geometry();
    wait_for_results();
    repeat (TailCycles) @(posedge clk_i);
    while (chs_expected_q.size() != 0)
      report_mismatch("result never arrived", 24'h0, chs_expected_q.pop_front());
    $display("Sent %0d addresses under %0d register writes, %0d of them past the geometry",
             items_sent, geometry_writes, clamped_items);
    $display("Checked %0d results, %0d mismatches, %0d cycles", results_seen, mismatches,
             cycles);
    if (mismatches == 0) begin
      $display("lba_to_chs_converter verification clean");
    end else begin
      $display("lba_to_chs_converter verification failed");
    end
    $finish;
  end

endmodule

[lba_to_chs_converter.f]
+incdir+sv
sv/lbac_pkg.sv
sv/lbac_front.sv
sv/lbac_cell.sv
sv/lba_to_chs_converter.sv
sim/testbench.sv
